// File: rtl/core/pmd_pkg.sv
// shared types and constants for the ps/2 mouse packet decoder
`timescale 1ns / 1ps
package pmd_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [2:0] WHEEL_LEN = 3'd4;
	localparam logic [2:0] RESET_LEN = 3'd3;

	localparam int EV_W = 5;
	localparam int EV_MOTION = 0;
	localparam int EV_LEFT   = 1;
	localparam int EV_RIGHT  = 2;
	localparam int EV_MIDDLE = 3;
	localparam int EV_WHEEL  = 4;

	typedef enum logic [1:0] {
		KIND_MOTION  = 2'd0,
		KIND_PRESS   = 2'd1,
		KIND_RELEASE = 2'd2,
		KIND_WHEEL   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		BTN_NONE   = 2'd0,
		BTN_LEFT   = 2'd1,
		BTN_RIGHT  = 2'd2,
		BTN_MIDDLE = 2'd3
	} button_t;

	typedef struct packed {
		logic signed [8:0] dx;
		logic signed [9:0] dy;
		logic [2:0]        buttons;
		logic signed [3:0] wheel;
		logic [EV_W-1:0]   mask;
	} packet_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: rtl/core/pmd_front.sv
// front end: byte collection, resync and packet classification
`timescale 1ns / 1ps
module pmd_front import pmd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	input  logic       in_fire,
	input  logic [7:0] data_byte,
	input  logic       byte_error,
	output logic       push,
	output packet_t    push_pkt
);

	logic [2:0] packet_length_q;
	logic [1:0] byte_count_q;
	logic [7:0] b0_q, b1_q, b2_q;
	logic [2:0] button_state_q;

	logic       wheel_mode;
	logic       take;
	logic       done;
	logic [7:0] byte2;
	logic signed [8:0] dy9;

	assign wheel_mode = (packet_length_q == WHEEL_LEN);
	assign take = in_fire && !byte_error && !(byte_count_q == 2'd0 && !data_byte[3]);
	assign done = take && (wheel_mode ? (byte_count_q == 2'd3) : (byte_count_q == 2'd2));
	assign byte2 = (byte_count_q == 2'd2) ? data_byte : b2_q;
	assign dy9 = {b0_q[5], byte2};

	always_comb begin
		push_pkt.dx = {b0_q[4], b1_q};
		push_pkt.dy = -{dy9[8], dy9};
		push_pkt.buttons = b0_q[2:0];
		push_pkt.wheel = data_byte[3:0];
		push_pkt.mask[EV_MOTION] = (push_pkt.dx != 9'sd0) || (push_pkt.dy != 10'sd0);
		push_pkt.mask[EV_LEFT]   = b0_q[0] ^ button_state_q[0];
		push_pkt.mask[EV_RIGHT]  = b0_q[1] ^ button_state_q[1];
		push_pkt.mask[EV_MIDDLE] = b0_q[2] ^ button_state_q[2];
		push_pkt.mask[EV_WHEEL]  = wheel_mode && (data_byte[3:0] != 4'd0);
	end

	assign push = done && (push_pkt.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_length_q <= RESET_LEN;
			byte_count_q <= 2'd0;
			button_state_q <= 3'd0;
		end else if (cfg_we) begin
			packet_length_q <= cfg_wdata;
			byte_count_q <= 2'd0;
		end else if (take) begin
			if (done) begin
				byte_count_q <= 2'd0;
				button_state_q <= b0_q[2:0];
			end else begin
				byte_count_q <= byte_count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			unique case (byte_count_q)
				2'd0: b0_q <= data_byte;
				2'd1: b1_q <= data_byte;
				2'd2: b2_q <= data_byte;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/pmd_queue.sv
// short packet queue between front and back ends
`timescale 1ns / 1ps
module pmd_queue import pmd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  packet_t   push_pkt,
	input  logic      pop,
	output packet_t   head,
	output q_status_t status
);

	packet_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign status.full  = (count_q == QCNT_W'(QDEPTH));
	assign status.empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_pkt;
		end
	end

endmodule

// File: rtl/core/pmd_back.sv
// back end: expands one packet into its event beats
`timescale 1ns / 1ps
module pmd_back import pmd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  packet_t           head,
	input  q_status_t         status,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output kind_t             out_kind,
	output button_t           out_button,
	output logic signed [8:0] out_dx,
	output logic signed [9:0] out_dy,
	output logic              out_last
);

	packet_t          cur_q;
	logic [EV_W-1:0]  mask_q;
	logic             valid_q;
	kind_t            kind_q;
	button_t          button_q;
	logic signed [8:0] dx_q;
	logic signed [9:0] dy_q;
	logic             last_q;

	logic             advance;
	logic [EV_W-1:0]  pick;
	logic [EV_W-1:0]  mask_next;
	kind_t            kind_d;
	button_t          button_d;
	logic signed [8:0] dx_d;
	logic signed [9:0] dy_d;

	assign advance = (mask_q != '0) && (!valid_q || out_ready);
	assign pick = mask_q & (~mask_q + 1'b1);
	assign mask_next = mask_q & ~pick;
	assign pop = !status.empty && ((mask_q == '0) || (advance && mask_next == '0));

	always_comb begin
		kind_d = KIND_MOTION;
		button_d = BTN_NONE;
		dx_d = '0;
		dy_d = '0;
		priority if (pick[EV_MOTION]) begin
			dx_d = cur_q.dx;
			dy_d = cur_q.dy;
		end else if (pick[EV_LEFT]) begin
			kind_d = cur_q.buttons[0] ? KIND_PRESS : KIND_RELEASE;
			button_d = BTN_LEFT;
		end else if (pick[EV_RIGHT]) begin
			kind_d = cur_q.buttons[1] ? KIND_PRESS : KIND_RELEASE;
			button_d = BTN_RIGHT;
		end else if (pick[EV_MIDDLE]) begin
			kind_d = cur_q.buttons[2] ? KIND_PRESS : KIND_RELEASE;
			button_d = BTN_MIDDLE;
		end else begin
			kind_d = KIND_WHEEL;
			dy_d = 10'(cur_q.wheel);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= head.mask;
			end else if (advance) begin
				mask_q <= mask_next;
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (advance) begin
			kind_q <= kind_d;
			button_q <= button_d;
			dx_q <= dx_d;
			dy_q <= dy_d;
			last_q <= (mask_next == '0);
		end
	end

	assign out_valid = valid_q;
	assign out_kind = kind_q;
	assign out_button = button_q;
	assign out_dx = dx_q;
	assign out_dy = dy_q;
	assign out_last = last_q;

endmodule

// File: rtl/core/ps2_mouse_packet_decoder.sv
// top level of the ps/2 mouse packet decoder
// one byte beat per cycle while the packet queue has room
// events leave one per cycle while m_tready is high; a packet of n events leaves as n beats
// a packet is queued with its last byte, then loaded into the back end, then its first event is registered
// reset: packet length 3, byte count zero, all buttons released, queue and output empty
`timescale 1ns / 1ps
module ps2_mouse_packet_decoder import pmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte[7:0]
	input  logic        s_tuser,  // byte_error
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // button_id[1:0], delta_x[10:2], delta_y[20:11], zero pad
	output logic [1:0]  m_tuser,  // event_kind[1:0]
	output logic        m_tlast
);

	logic      push, pop;
	packet_t   push_pkt, head;
	q_status_t status;
	kind_t     kind;
	button_t   button;
	logic signed [8:0] dx;
	logic signed [9:0] dy;

	assign s_tready = !status.full;

	pmd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_fire    (s_tvalid && s_tready),
		.data_byte  (s_tdata),
		.byte_error (s_tuser),
		.push       (push),
		.push_pkt   (push_pkt)
	);

	pmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_pkt (push_pkt),
		.pop      (pop),
		.head     (head),
		.status   (status)
	);

	pmd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.status     (status),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (kind),
		.out_button (button),
		.out_dx     (dx),
		.out_dy     (dy),
		.out_last   (m_tlast)
	);

	assign m_tdata = {3'b000, dy, dx, button};
	assign m_tuser = kind;

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full))
		else $error("packet pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && status.empty))
		else $error("packet popped from empty queue");

	a_button_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (kind == KIND_PRESS || kind == KIND_RELEASE)
		|-> button != BTN_NONE && dx == 9'sd0 && dy == 10'sd0)
		else $error("button beat with bad payload");

	a_motion_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind == KIND_MOTION |-> button == BTN_NONE && (dx != 9'sd0 || dy != 10'sd0))
		else $error("motion beat with bad payload");

endmodule

// File: tb/sv/ps2_mouse_packet_decoder_tb.sv
// testbench for the ps/2 mouse packet decoder: directed packets, then random byte streams
`timescale 1ns / 1ps
module ps2_mouse_packet_decoder_tb;
	import pmd_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int BYTES_PER_PHASE = 41;
	localparam int DIR_ROWS = 26;

	typedef struct packed {
		kind_t             kind;
		button_t           btn;
		logic signed [8:0] dx;
		logic signed [9:0] dy;
		logic              last;
	} mouse_ev_t;

	typedef enum logic [1:0] {
		ROW_MODEL,
		ROW_NONE,
		ROW_ONE,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [7:0] data;
		logic       err;
		mouse_ev_t  ev;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;  // data_byte[7:0]
	logic        s_tuser;  // byte_error
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;  // button_id[1:0], delta_x[10:2], delta_y[20:11], zero pad
	logic [1:0]  m_tuser;  // event_kind[1:0]
	logic        m_tlast;

	mouse_ev_t events_due[$];
	int fails = 0;
	int quiet = 0;
	int snd_pct = 0;
	int rcv_pct = 0;

	// decoder state as the testbench sees it
	logic [2:0] len_reg;
	int         byte_cnt;
	logic [7:0] pkt_buf [3];
	logic [2:0] btn_held;

	row_t       dir_rows [DIR_ROWS];
	logic [2:0] len_plan [PHASES];

	ps2_mouse_packet_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= (rcv_pct == 0) || ($urandom_range(99) >= rcv_pct);
	end

	task automatic decode_mouse_byte(input logic [7:0] b, input logic err, input bit keep,
			output bit took);
		mouse_ev_t  evs [5];
		int         n;
		bit         wheel_mode;
		logic [2:0] btns;
		logic [2:0] chg;
		logic [8:0] x9;
		logic [8:0] y9;
		logic [9:0] ny;
		n = 0;
		took = 1'b0;
		wheel_mode = (len_reg == WHEEL_LEN);
		if (err || (byte_cnt == 0 && !b[3]))
			return;
		took = 1'b1;
		if (byte_cnt < 3)
			pkt_buf[byte_cnt] = b;
		byte_cnt++;
		if (byte_cnt < (wheel_mode ? 4 : 3))
			return;
		byte_cnt = 0;
		btns = pkt_buf[0][2:0];
		chg = btns ^ btn_held;
		x9 = {pkt_buf[0][4], pkt_buf[1]};
		y9 = {pkt_buf[0][5], pkt_buf[2]};
		ny = -{y9[8], y9};
		if (x9 != 9'h0 || ny != 10'h0) begin
			evs[n] = '{KIND_MOTION, BTN_NONE, x9, ny, 1'b0};
			n++;
		end
		for (int i = 0; i < 3; i++) begin
			if (chg[i]) begin
				evs[n] = '{btns[i] ? KIND_PRESS : KIND_RELEASE, button_t'(i + 1),
					9'h0, 10'h0, 1'b0};
				n++;
			end
		end
		btn_held = btns;
		// wheel nibble comes from the fourth byte itself
		if (wheel_mode && b[3:0] != 4'h0) begin
			evs[n] = '{KIND_WHEEL, BTN_NONE, 9'h0, {{6{b[3]}}, b[3:0]}, 1'b0};
			n++;
		end
		if (n > 0)
			evs[n - 1].last = 1'b1;
		if (keep) begin
			for (int i = 0; i < n; i++)
				events_due.push_back(evs[i]);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic err, input row_kind_t rk,
			input mouse_ev_t typed, output bit took);
		@(negedge clk);
		while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= err;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_mouse_byte(b, err, rk == ROW_MODEL, took);
		if (rk == ROW_ONE)
			events_due.push_back(typed);
	endtask

	task automatic wait_drained;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (events_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_len(input logic [2:0] v);
		wait_drained;
		// a packet with no events may still be in flight
		repeat (10) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		len_reg = v;
		byte_cnt = 0;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		mouse_ev_t got;
		mouse_ev_t want;
		if (m_tvalid && m_tready) begin
			got = '{kind_t'(m_tuser), button_t'(m_tdata[1:0]), m_tdata[10:2],
				m_tdata[20:11], m_tlast};
			if (events_due.size() == 0) begin
				$display("%0t: event beat with none expected, expected nothing, actual %h",
					$time, got);
				fails++;
			end else begin
				want = events_due.pop_front();
				check_field("event_kind", int'(want.kind), int'(got.kind));
				check_field("button_id", int'(want.btn), int'(got.btn));
				check_field("delta_x", int'(want.dx), int'(got.dx));
				check_field("delta_y", int'(want.dy), int'(got.dy));
				check_field("last_event", int'(want.last), int'(got.last));
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d events outstanding", $time, quiet,
				events_due.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [7:0] b;
		bit         took;
		bit         held;
		int         taken;
		int         plen;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 3'd0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		len_reg = RESET_LEN;
		byte_cnt = 0;
		btn_held = 3'b000;

		dir_rows = '{
			// dropped bytes: flagged error, then a first byte without the sync bit
			'{ROW_NONE, 8'h08, 1'b1, '0},
			'{ROW_NONE, 8'h07, 1'b0, '0},
			// empty packet
			'{ROW_NONE, 8'h08, 1'b0, '0},
			'{ROW_NONE, 8'h00, 1'b0, '0},
			'{ROW_NONE, 8'h00, 1'b0, '0},
			// most negative x, y negates to +256
			'{ROW_NONE, 8'h38, 1'b0, '0},
			'{ROW_NONE, 8'h00, 1'b0, '0},
			'{ROW_ONE,  8'h00, 1'b0, '{KIND_MOTION, BTN_NONE, 9'h100, 10'h100, 1'b1}},
			// most positive x and y
			'{ROW_NONE, 8'h08, 1'b0, '0},
			'{ROW_NONE, 8'hFF, 1'b0, '0},
			'{ROW_ONE,  8'hFF, 1'b0, '{KIND_MOTION, BTN_NONE, 9'h0FF, 10'h301, 1'b1}},
			// overflow bits ignored, left press only
			'{ROW_NONE, 8'hC9, 1'b0, '0},
			'{ROW_NONE, 8'h00, 1'b0, '0},
			'{ROW_ONE,  8'h00, 1'b0, '{KIND_PRESS, BTN_LEFT, 9'h0, 10'h0, 1'b1}},
			// motion plus release left, press right and middle
			'{ROW_MODEL, 8'h0E, 1'b0, '0},
			'{ROW_MODEL, 8'h01, 1'b0, '0},
			'{ROW_MODEL, 8'h7F, 1'b0, '0},
			'{ROW_CFG,   8'h04, 1'b0, '0},
			// wheel packets: most negative delta with releases, then most positive alone
			'{ROW_MODEL, 8'h08, 1'b0, '0},
			'{ROW_MODEL, 8'h00, 1'b0, '0},
			'{ROW_MODEL, 8'h00, 1'b0, '0},
			'{ROW_MODEL, 8'h08, 1'b0, '0},
			'{ROW_NONE, 8'h08, 1'b0, '0},
			'{ROW_NONE, 8'h00, 1'b0, '0},
			'{ROW_NONE, 8'h00, 1'b0, '0},
			'{ROW_ONE,  8'hF7, 1'b0, '{KIND_WHEEL, BTN_NONE, 9'h0, 10'h007, 1'b1}}
		};
		len_plan = '{3'd7, WHEEL_LEN, 3'd0, RESET_LEN, WHEEL_LEN, 3'd2, WHEEL_LEN, 3'd5};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_len(dir_rows[i].data[2:0]);
			else
				send_byte(dir_rows[i].data, dir_rows[i].err, dir_rows[i].kind,
					dir_rows[i].ev, took);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_len(len_plan[p]);
			case (p % 4)
				0: begin snd_pct = 0;  rcv_pct = 0;  end
				1: begin snd_pct = 74; rcv_pct = 0;  end
				2: begin snd_pct = 0;  rcv_pct = 74; end
				default: begin snd_pct = 10; rcv_pct = 10; end
			endcase
			taken = 0;
			held = 1'b0;
			while (taken < BYTES_PER_PHASE) begin
				plen = (len_reg == WHEEL_LEN) ? 4 : 3;
				// stray byte between packets
				if ($urandom_range(99) < 8) begin
					send_byte(8'($urandom), 1'($urandom), ROW_MODEL, '0, took);
					taken += took;
				end
				// cut-short packet
				if ($urandom_range(99) < 6)
					plen = $urandom_range(plen - 1, 1);
				for (int k = 0; k < plen; k++) begin
					b = 8'($urandom);
					case (k)
						0: begin
							b[3] = 1'b1;
							if ($urandom_range(1) == 0)
								b[2:0] = btn_held;
						end
						3: if ($urandom_range(3) == 0) b[3:0] = 4'h0;
						default: if ($urandom_range(3) == 0) b = 8'h00;
					endcase
					if ($urandom_range(99) < 4)
						send_byte(8'($urandom), 1'b1, ROW_MODEL, '0, took);
					send_byte(b, 1'b0, ROW_MODEL, '0, took);
					taken += took;
				end
				if (!held && taken >= BYTES_PER_PHASE / 2) begin
					wait_drained;
					held = 1'b1;
				end
			end
		end

		wait_drained;
		repeat (20) @(negedge clk);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
